// ===== rtl/mfhp_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the multicast fragment header parser.
// No dependencies; imported by every module of the block.
package mfhp_pkg;

   localparam int ID_OFFSET   = 20;
   localparam int RSP_DEPTH   = 3;
   localparam int RSP_CNT_W   = 2;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 8;

   localparam logic [CSR_INDEX_W-1:0] CSR_EXPECTED_VERSION = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_ID_LENGTH    = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_MIN_HEADER_BYTES = 2'd2;

   localparam logic [7:0] EXPECTED_VERSION_RST = 8'd16;
   localparam logic [7:0] MAX_ID_LENGTH_RST    = 8'd252;
   localparam logic [6:0] MIN_HEADER_BYTES_RST = 7'd20;

   localparam logic [7:0] MAGIC_BYTES [4] = '{8'h4D, 8'h49, 8'h4F, 8'h50};

   typedef enum logic [2:0] {
      ST_OK          = 3'd0,
      ST_TOO_SHORT   = 3'd1,
      ST_BAD_MAGIC   = 3'd2,
      ST_BAD_VERSION = 3'd3,
      ST_MALFORMED   = 3'd4,
      ST_NO_PAD      = 3'd5
   } status_type;

   typedef struct packed {
      logic [7:0] expected_version;
      logic [7:0] max_id_length;
      logic [6:0] min_header_bytes;
   } cfg_type;

   typedef struct packed {
      status_type  status;
      logic        stop_fragment;
      logic [15:0] payload_length;
      logic [31:0] fragment_number;
      logic [31:0] id_hash;
      logic [8:0]  payload_offset;
   } rsp_type;

endpackage

// ===== rtl/mfhp_parse.sv =====
`timescale 1ns / 1ps
// Per-byte header parse, identifier hash and end-of-datagram status check.
// Depends on mfhp_pkg.
module mfhp_parse #(
   parameter int MAX_DGRAM_BYTES = 65536
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             beat_valid,
   input  logic [7:0]       beat_byte,
   input  logic             beat_last,
   input  mfhp_pkg::cfg_type cfg,
   output logic             rsp_push,
   output mfhp_pkg::rsp_type rsp_data
);
   import mfhp_pkg::*;

   localparam int CNT_W = $clog2(MAX_DGRAM_BYTES + 2);

   logic [CNT_W-1:0] byte_count_ff, byte_count_in, upd_count;
   status_type       first_error_ff, first_error_in, upd_error;
   logic             little_endian_ff, little_endian_in, upd_le;
   logic             stop_seen_ff, stop_seen_in, upd_stop;
   logic [15:0]      length_field_ff, length_field_in, upd_length;
   logic [31:0]      number_field_ff, number_field_in, upd_number;
   logic [31:0]      ident_length_ff, ident_length_in, upd_ident;
   logic [31:0]      hash_accum_ff, hash_accum_in, upd_hash;

   logic             in_range;
   logic [CNT_W-1:0] pos;
   logic [31:0]      hash_pos;
   logic [31:0]      len_asm;
   logic [31:0]      hash_step;
   logic [33:0]      total_len;
   logic [8:0]       offset_sum;
   logic [8:0]       offset;
   status_type       status;

   function automatic logic [31:0] assemble(input logic [31:0] old_val,
                                            input logic [7:0]  b,
                                            input logic [1:0]  k,
                                            input logic        le);
      logic [31:0] base;
      logic [31:0] res;
      base = (k == 2'd0) ? 32'd0 : old_val;
      if (le) begin
         res = base | ({24'd0, b} << {k, 3'b000});
      end else begin
         res = {base[23:0], b};
      end
      return res;
   endfunction

   assign pos      = byte_count_ff;
   assign in_range = byte_count_ff < CNT_W'(MAX_DGRAM_BYTES);
   assign hash_pos = 32'(pos - CNT_W'(ID_OFFSET));
   assign len_asm  = assemble({16'd0, length_field_ff}, beat_byte, pos[1:0] ^ 2'b10,
                              little_endian_ff);

   // PJW step: shift in the byte, fold the top nibble back into bits 7:4
   always_comb begin
      hash_step = {hash_accum_ff[27:0], 4'd0} + {24'd0, beat_byte};
      if (hash_step[31:28] != 4'd0) begin
         hash_step[7:4]   = hash_step[7:4] ^ hash_step[31:28];
         hash_step[31:28] = 4'd0;
      end
   end

   always_comb begin
      upd_count  = byte_count_ff;
      upd_error  = first_error_ff;
      upd_le     = little_endian_ff;
      upd_stop   = stop_seen_ff;
      upd_length = length_field_ff;
      upd_number = number_field_ff;
      upd_ident  = ident_length_ff;
      upd_hash   = hash_accum_ff;
      if (beat_valid) begin
         if (in_range) begin
            upd_count = byte_count_ff + CNT_W'(1);
            if (pos < CNT_W'(4)) begin
               if (beat_byte != MAGIC_BYTES[pos[1:0]] && first_error_ff == ST_OK) begin
                  upd_error = ST_BAD_MAGIC;
               end
            end else if (pos == CNT_W'(4)) begin
               if (beat_byte != cfg.expected_version && first_error_ff == ST_OK) begin
                  upd_error = ST_BAD_VERSION;
               end
            end else if (pos == CNT_W'(5)) begin
               upd_stop = beat_byte[1];
               upd_le   = beat_byte[0];
            end else if (pos < CNT_W'(8)) begin
               upd_length = len_asm[15:0];
            end else if (pos < CNT_W'(12)) begin
               upd_number = assemble(number_field_ff, beat_byte, pos[1:0], little_endian_ff);
            end else if (pos < CNT_W'(16)) begin
               // packet count is not used
            end else if (pos < CNT_W'(ID_OFFSET)) begin
               upd_ident = assemble(ident_length_ff, beat_byte, pos[1:0], little_endian_ff);
            end else if (hash_pos < ident_length_ff) begin
               upd_hash = hash_step;
            end
         end else begin
            upd_count = CNT_W'(MAX_DGRAM_BYTES + 1);
         end
      end
   end

   assign total_len  = 34'(upd_ident) + 34'(upd_length) + 34'(ID_OFFSET);
   assign offset_sum = {1'b0, upd_ident[7:0]} + 9'(ID_OFFSET + 7);
   assign offset     = offset_sum & ~9'd7;

   always_comb begin
      if (32'(upd_count) < 32'(cfg.min_header_bytes)) begin
         status = ST_TOO_SHORT;
      end else if (upd_error != ST_OK) begin
         status = upd_error;
      end else if (upd_count < CNT_W'(4)) begin
         status = ST_BAD_MAGIC;
      end else if (upd_count == CNT_W'(4) && cfg.expected_version != 8'd0) begin
         status = ST_BAD_VERSION;
      end else if (upd_count < CNT_W'(ID_OFFSET) ||
                   32'(upd_count) > 32'(MAX_DGRAM_BYTES)) begin
         status = ST_MALFORMED;
      end else if (upd_ident > {24'd0, cfg.max_id_length} ||
                   total_len != 34'(upd_count)) begin
         status = ST_MALFORMED;
      end else if (32'(offset) > 32'(upd_count)) begin
         status = ST_NO_PAD;
      end else begin
         status = ST_OK;
      end
   end

   always_comb begin
      rsp_push = beat_valid && beat_last;
      rsp_data = '0;
      rsp_data.status = status;
      if (status == ST_OK) begin
         rsp_data.stop_fragment   = upd_stop;
         rsp_data.payload_length  = upd_length;
         rsp_data.fragment_number = upd_number;
         rsp_data.id_hash         = upd_hash;
         rsp_data.payload_offset  = offset;
      end
   end

   // datagram state returns to zero after its last beat
   always_comb begin
      if (rsp_push) begin
         byte_count_in    = '0;
         first_error_in   = ST_OK;
         little_endian_in = 1'b0;
         stop_seen_in     = 1'b0;
         length_field_in  = '0;
         number_field_in  = '0;
         ident_length_in  = '0;
         hash_accum_in    = '0;
      end else begin
         byte_count_in    = upd_count;
         first_error_in   = upd_error;
         little_endian_in = upd_le;
         stop_seen_in     = upd_stop;
         length_field_in  = upd_length;
         number_field_in  = upd_number;
         ident_length_in  = upd_ident;
         hash_accum_in    = upd_hash;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_count_ff    <= '0;
         first_error_ff   <= ST_OK;
         little_endian_ff <= 1'b0;
         stop_seen_ff     <= 1'b0;
         length_field_ff  <= '0;
         number_field_ff  <= '0;
         ident_length_ff  <= '0;
         hash_accum_ff    <= '0;
      end else begin
         byte_count_ff    <= byte_count_in;
         first_error_ff   <= first_error_in;
         little_endian_ff <= little_endian_in;
         stop_seen_ff     <= stop_seen_in;
         length_field_ff  <= length_field_in;
         number_field_ff  <= number_field_in;
         ident_length_ff  <= ident_length_in;
         hash_accum_ff    <= hash_accum_in;
      end
   end

`ifndef SYNTHESIS
   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      32'(byte_count_ff) <= 32'(MAX_DGRAM_BYTES + 1))
      else $error("byte count past saturation value");
   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      rsp_push |=> (byte_count_ff == '0 && first_error_ff == ST_OK && hash_accum_ff == '0))
      else $error("datagram state not cleared after last beat");
   a_ok_needs_min_len: assert property (@(posedge clock) disable iff (reset)
      (rsp_push && rsp_data.status == ST_OK) |-> 32'(upd_count) >= 32'(ID_OFFSET))
      else $error("ok status on a datagram shorter than the header");
`endif

endmodule

// ===== rtl/mfhp_rsp_queue.sv =====
`timescale 1ns / 1ps
// Small result queue; head entry drives the result ports from a register.
// Depends on mfhp_pkg.
module mfhp_rsp_queue (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           push,
   input  mfhp_pkg::rsp_type              push_data,
   input  logic                           rsp_stall,
   output logic                           rsp_valid,
   output mfhp_pkg::rsp_type              head,
   output logic [mfhp_pkg::RSP_CNT_W-1:0] count_next
);
   import mfhp_pkg::*;

   rsp_type              slot_ff [RSP_DEPTH];
   rsp_type              slot_in [RSP_DEPTH];
   logic [RSP_CNT_W-1:0] count_ff, count_in, after_pop;
   logic                 pop;

   assign rsp_valid  = count_ff != '0;
   assign head       = slot_ff[0];
   assign pop        = rsp_valid && !rsp_stall;
   assign after_pop  = count_ff - RSP_CNT_W'(pop);
   assign count_in   = after_pop + RSP_CNT_W'(push);
   assign count_next = count_in;

   // entries shift toward the head on a pop; new beat lands behind the rest
   always_comb begin
      for (int i = 0; i < RSP_DEPTH; i++) begin
         if (pop) begin
            slot_in[i] = slot_ff[(i < RSP_DEPTH - 1) ? i + 1 : i];
         end else begin
            slot_in[i] = slot_ff[i];
         end
         if (push && RSP_CNT_W'(i) == after_pop) begin
            slot_in[i] = push_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < RSP_DEPTH; i++) begin
         slot_ff[i] <= slot_in[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> after_pop < RSP_CNT_W'(RSP_DEPTH))
      else $error("result pushed into full queue");
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= RSP_CNT_W'(RSP_DEPTH))
      else $error("queue count out of range");
   a_empty_push_head: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0 && push) |=> head == $past(push_data))
      else $error("pushed beat not at head of empty queue");
`endif

endmodule

// ===== rtl/multicast_fragment_header_parser_unit.sv =====
`timescale 1ns / 1ps
// A last byte lands in the input beat register; its result is then written to the result queue.
// Throughput: one byte per cycle while req_stall is low; stall rises once queued and in-flight results reach three.
// Bytes without the last mark give no result. Registers: input beat register, parse
// state, three-entry result queue. Reset (synchronous) empties the pipe, clears the
// datagram state and restores the registers to version 16, id limit 252, min size 20.
module multicast_fragment_header_parser_unit #(
   parameter int MAX_DGRAM_BYTES = 65536
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [7:0]                       req_rx_byte,
   input  logic                             req_last_byte,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [2:0]                       rsp_status,
   output logic                             rsp_stop_fragment,
   output logic [15:0]                      rsp_payload_length,
   output logic [31:0]                      rsp_fragment_number,
   output logic [31:0]                      rsp_id_hash,
   output logic [8:0]                       rsp_payload_offset,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [mfhp_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [mfhp_pkg::CSR_DATA_W-1:0]  csr_data
);
   import mfhp_pkg::*;

   cfg_type              cfg_ff, cfg_in;
   logic                 beat_valid_ff, beat_valid_in;
   logic [7:0]           beat_byte_ff;
   logic                 beat_last_ff;
   logic                 req_stall_ff, req_stall_in;
   logic                 accept;
   logic                 push;
   rsp_type              push_data;
   rsp_type              head;
   logic [RSP_CNT_W-1:0] q_count_next;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_EXPECTED_VERSION: cfg_in.expected_version = csr_data;
            CSR_MAX_ID_LENGTH:    cfg_in.max_id_length    = csr_data;
            CSR_MIN_HEADER_BYTES: cfg_in.min_header_bytes = csr_data[6:0];
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   assign accept        = req_valid && !req_stall_ff;
   assign beat_valid_in = accept;
   assign req_stall     = req_stall_ff;

   // room check counts the beat in flight, which may push one more result
   assign req_stall_in = ({1'b0, q_count_next} + (RSP_CNT_W+1)'(accept && req_last_byte))
                         >= (RSP_CNT_W+1)'(RSP_DEPTH);

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.expected_version <= EXPECTED_VERSION_RST;
         cfg_ff.max_id_length    <= MAX_ID_LENGTH_RST;
         cfg_ff.min_header_bytes <= MIN_HEADER_BYTES_RST;
         beat_valid_ff           <= 1'b0;
         req_stall_ff            <= 1'b0;
      end else begin
         cfg_ff        <= cfg_in;
         beat_valid_ff <= beat_valid_in;
         req_stall_ff  <= req_stall_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         beat_byte_ff <= req_rx_byte;
         beat_last_ff <= req_last_byte;
      end
   end

   mfhp_parse #(
      .MAX_DGRAM_BYTES(MAX_DGRAM_BYTES)
   ) u_parse (
      .clock      (clock),
      .reset      (reset),
      .beat_valid (beat_valid_ff),
      .beat_byte  (beat_byte_ff),
      .beat_last  (beat_last_ff),
      .cfg        (cfg_ff),
      .rsp_push   (push),
      .rsp_data   (push_data)
   );

   mfhp_rsp_queue u_rsp_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_data  (push_data),
      .rsp_stall  (rsp_stall),
      .rsp_valid  (rsp_valid),
      .head       (head),
      .count_next (q_count_next)
   );

   assign rsp_status          = head.status;
   assign rsp_stop_fragment   = head.stop_fragment;
   assign rsp_payload_length  = head.payload_length;
   assign rsp_fragment_number = head.fragment_number;
   assign rsp_id_hash         = head.id_hash;
   assign rsp_payload_offset  = head.payload_offset;

`ifndef SYNTHESIS
   a_stall_when_full: assert property (@(posedge clock) disable iff (reset)
      (q_count_next == RSP_CNT_W'(RSP_DEPTH)) |=> req_stall)
      else $error("input open with full result queue");
   a_no_beat_after_stall: assert property (@(posedge clock) disable iff (reset)
      req_stall |=> !beat_valid_ff)
      else $error("beat loaded while stalled");
   a_push_from_last: assert property (@(posedge clock) disable iff (reset)
      push |-> (beat_valid_ff && beat_last_ff))
      else $error("result without a last beat");
`endif

endmodule
